[rtl/oav_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oav_pkg
// Shared types and constants of the oscillator voice with linear envelope.
// ----------------------------------------------------------------------------
package oav_pkg;

  localparam int WAVE_W   = 3;
  localparam int STEP_W   = 23;
  localparam int GAIN_W   = 16;
  localparam int LEN_W    = 20;
  localparam int LEVEL_W  = 16;
  localparam int SAMPLE_W = 16;
  localparam int INDEX_W  = 22;
  localparam int LFSR_W   = 16;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 23;

  // serial multiplier: MUL_A_W x MUL_B_W, one multiplier bit per cycle
  localparam int MUL_A_W   = 32;
  localparam int MUL_B_W   = 17;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

  // serial divider: DIV_Q_W quotient bits, one per cycle
  localparam int DIV_D_W   = 20;
  localparam int DIV_Q_W   = 16;
  localparam int DIV_CNT_W = $clog2(DIV_Q_W + 1);

  localparam logic [CFG_INDEX_W-1:0] REG_WAVE_SELECT    = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP     = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_GAIN    = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ATTACK_LENGTH  = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DECAY_LENGTH   = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_LENGTH    = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_LENGTH = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SUSTAIN_LEVEL  = 4'd7;

  localparam logic [WAVE_W-1:0] WAVE_SINE     = 3'd0;
  localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 3'd1;
  localparam logic [WAVE_W-1:0] WAVE_SAW      = 3'd2;
  localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 3'd3;
  localparam logic [WAVE_W-1:0] WAVE_NOISE    = 3'd4;

  localparam logic [WAVE_W-1:0]  RESET_WAVE_SELECT    = WAVE_SINE;
  localparam logic [STEP_W-1:0]  RESET_PHASE_STEP     = 23'd99533;
  localparam logic [GAIN_W-1:0]  RESET_OUTPUT_GAIN    = 16'd32768;
  localparam logic [LEN_W-1:0]   RESET_ATTACK_LENGTH  = 20'd441;
  localparam logic [LEN_W-1:0]   RESET_DECAY_LENGTH   = 20'd4410;
  localparam logic [LEN_W-1:0]   RESET_HOLD_LENGTH    = 20'd74529;
  localparam logic [LEN_W-1:0]   RESET_RELEASE_LENGTH = 20'd8820;
  localparam logic [LEVEL_W-1:0] RESET_SUSTAIN_LEVEL  = 16'd45875;

  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

  typedef enum logic [2:0] {
    STAGE_ATTACK  = 3'd0,
    STAGE_DECAY   = 3'd1,
    STAGE_SUSTAIN = 3'd2,
    STAGE_RELEASE = 3'd3,
    STAGE_IDLE    = 3'd4
  } env_stage_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM1,
    ST_SUM2,
    ST_EVAL,
    ST_SETUP,
    ST_PMUL,
    ST_DIVGO,
    ST_DIV,
    ST_WGO,
    ST_WMUL,
    ST_GGO,
    ST_GMUL,
    ST_DONE
  } voice_state_t;

endpackage
`default_nettype wire

[rtl/oav_sine_rom.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oav_sine_rom
// Quarter-wave sine table with registered read; returns magnitude and sign.
// ----------------------------------------------------------------------------
module oav_sine_rom #(
  parameter int SINE_TABLE_ENTRIES = 1024
) (
  input  logic                                  clk,
  input  logic [$clog2(SINE_TABLE_ENTRIES)-1:0] addr,
  output logic [14:0]                           mag,
  output logic                                  neg
);

  localparam int IDX_W = $clog2(SINE_TABLE_ENTRIES);
  localparam int QBITS = IDX_W - 2;
  localparam int QN    = SINE_TABLE_ENTRIES / 4;

  typedef logic [14:0] qtab_t [QN+1];

  function automatic qtab_t build_qtab();
    qtab_t       tab;
    logic [63:0] one;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] a;
    logic [63:0] s;
    logic [63:0] v;
    one = 64'd1 << 30;
    for (int m = 0; m <= QN; m++) begin
      r  = 64'(m) << (30 - QBITS);
      x  = (r * 64'd1686629713) >> 30;
      x2 = (x * x) >> 30;
      a  = one - x2 / 64'd72;
      a  = one - ((x2 * a) >> 30) / 64'd42;
      a  = one - ((x2 * a) >> 30) / 64'd20;
      a  = one - ((x2 * a) >> 30) / 64'd6;
      s  = (x * a) >> 30;
      v  = (s * 64'd32767 + (one >> 1)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      tab[m] = v[14:0];
    end
    return tab;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  logic [QBITS-1:0] low;
  logic [QBITS:0]   tab_addr;

  assign low      = addr[QBITS-1:0];
  assign tab_addr = addr[QBITS] ? ((QBITS+1)'(QN) - {1'b0, low}) : {1'b0, low};

  always_ff @(posedge clk) begin
    mag <= QTAB[tab_addr];
    neg <= addr[IDX_W-1];
  end

endmodule
`default_nettype wire

[rtl/oav_serial_mul.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oav_serial_mul
// Shift-and-add multiplier, one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module oav_serial_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [oav_pkg::MUL_A_W-1:0]   a,
  input  logic [oav_pkg::MUL_B_W-1:0]   b,
  output logic [oav_pkg::MUL_P_W-1:0]   product,
  output logic                          done
);

  localparam int AW = oav_pkg::MUL_A_W;
  localparam int BW = oav_pkg::MUL_B_W;
  localparam int PW = oav_pkg::MUL_P_W;
  localparam int CW = oav_pkg::MUL_CNT_W;

  logic [PW-1:0] acc;
  logic [AW-1:0] a_hold;
  logic [CW-1:0] cnt;
  logic [AW:0]   hi_sum;

  assign hi_sum  = {1'b0, acc[PW-1:BW]} + (acc[0] ? {1'b0, a_hold} : '0);
  assign product = acc;
  assign done    = (cnt == CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(BW);
    end else if (cnt != '0) begin
      cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= {{AW{1'b0}}, b};
      a_hold <= a;
    end else if (cnt != '0) begin
      acc <= {hi_sum, acc[BW-1:1]};
    end
  end

endmodule
`default_nettype wire

[rtl/oav_serial_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oav_serial_div
// Restoring divider, one quotient bit per cycle. The upper numerator part
// must be below the divisor so the quotient fits its width.
// ----------------------------------------------------------------------------
module oav_serial_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [oav_pkg::DIV_D_W-1:0]   num_hi,
  input  logic [oav_pkg::DIV_Q_W-1:0]   num_lo,
  input  logic [oav_pkg::DIV_D_W-1:0]   divisor,
  output logic [oav_pkg::DIV_Q_W-1:0]   quotient,
  output logic                          done
);

  localparam int DW = oav_pkg::DIV_D_W;
  localparam int QW = oav_pkg::DIV_Q_W;
  localparam int CW = oav_pkg::DIV_CNT_W;

  logic [DW-1:0] rem;
  logic [QW-1:0] quo;
  logic [DW-1:0] d_hold;
  logic [CW-1:0] cnt;
  logic [DW:0]   trial;
  logic [DW+1:0] diff;
  logic          ge;

  assign trial    = {rem, quo[QW-1]};
  assign diff     = {1'b0, trial} - {2'b00, d_hold};
  assign ge       = !diff[DW+1];
  assign quotient = quo;
  assign done     = (cnt == CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(QW);
    end else if (cnt != '0) begin
      cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= num_hi;
      quo    <= num_lo;
      d_hold <= divisor;
    end else if (cnt != '0) begin
      rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
      quo <= {quo[QW-2:0], ge};
    end
  end

endmodule
`default_nettype wire

[rtl/oscillator_adsr_voice_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oscillator_adsr_voice_top
// Phase accumulator oscillator with a linear attack/decay/sustain/release
// envelope and output gain, one audio sample per input item.
// Per item: silent when the note is idle; else the wave and gain products,
// led by a division in attack and by a product and a division in decay or
// release. One item at a time: a new item is accepted only after the last
// result is registered. The serial multiplier and divider do the arithmetic.
// Reset (synchronous): registers to defaults, phase and sample index zero,
// noise LFSR to 0xACE1, note idle. No clearing pass.
// ----------------------------------------------------------------------------
module oscillator_adsr_voice_top #(
  parameter int PHASE_BITS         = 24,
  parameter int SINE_TABLE_ENTRIES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [0] start_note, [7:1] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,    // [15:0] audio_sample, [18:16] env_stage, [23:19] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [22:0] cfg_data
);

  localparam int SINE_IDX_W = $clog2(SINE_TABLE_ENTRIES);
  localparam int SUM_W      = (PHASE_BITS > oav_pkg::STEP_W) ? PHASE_BITS : oav_pkg::STEP_W;

  logic [oav_pkg::WAVE_W-1:0]  wave_select;
  logic [oav_pkg::STEP_W-1:0]  phase_step;
  logic [oav_pkg::GAIN_W-1:0]  output_gain;
  logic [oav_pkg::LEN_W-1:0]   attack_length;
  logic [oav_pkg::LEN_W-1:0]   decay_length;
  logic [oav_pkg::LEN_W-1:0]   hold_length;
  logic [oav_pkg::LEN_W-1:0]   release_length;
  logic [oav_pkg::LEVEL_W-1:0] sustain_level;

  logic [oav_pkg::LEN_W:0]     e2;
  logic [oav_pkg::INDEX_W-1:0] e3;
  logic [oav_pkg::INDEX_W-1:0] e4;

  oav_pkg::voice_state_t state, state_next;

  logic [PHASE_BITS-1:0]       phase;
  logic [oav_pkg::INDEX_W-1:0] idx;
  logic [oav_pkg::LFSR_W-1:0]  lfsr;
  logic                        active;

  logic                        silent;
  oav_pkg::env_stage_t         stage;
  logic [oav_pkg::LEN_W-1:0]   jpos;
  logic [15:0]                 p16;
  logic [15:0]                 wmag;
  logic                        wneg;

  logic [oav_pkg::SAMPLE_W-1:0] out_sample;
  oav_pkg::env_stage_t          out_stage;

  logic                         accept;
  logic                         run;
  logic                         out_free;
  logic [SUM_W-1:0]             phase_sum;
  logic [oav_pkg::LFSR_W-1:0]   lfsr_step;
  oav_pkg::env_stage_t          stage_sel;
  logic [oav_pkg::LEN_W-1:0]    jpos_sel;
  logic [16:0]                  w17;
  logic [15:0]                  wave_mag;
  logic                         wave_neg;
  logic [16:0]                  env_val;
  logic [15:0]                  res_mag;
  logic [oav_pkg::SAMPLE_W-1:0] res_sample;

  logic [14:0]                  rom_mag;
  logic                         rom_neg;

  logic                         mul_start;
  logic [oav_pkg::MUL_A_W-1:0]  mul_a;
  logic [oav_pkg::MUL_B_W-1:0]  mul_b;
  logic [oav_pkg::MUL_P_W-1:0]  mul_prod;
  logic                         mul_done;

  logic                         div_start;
  logic [oav_pkg::DIV_D_W-1:0]  div_hi;
  logic [oav_pkg::DIV_Q_W-1:0]  div_lo;
  logic [oav_pkg::DIV_D_W-1:0]  div_d;
  logic [oav_pkg::DIV_Q_W-1:0]  div_q;
  logic                         div_done;

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign m_tdata   = {5'b00000, out_stage, out_sample};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wave_select    <= oav_pkg::RESET_WAVE_SELECT;
      phase_step     <= oav_pkg::RESET_PHASE_STEP;
      output_gain    <= oav_pkg::RESET_OUTPUT_GAIN;
      attack_length  <= oav_pkg::RESET_ATTACK_LENGTH;
      decay_length   <= oav_pkg::RESET_DECAY_LENGTH;
      hold_length    <= oav_pkg::RESET_HOLD_LENGTH;
      release_length <= oav_pkg::RESET_RELEASE_LENGTH;
      sustain_level  <= oav_pkg::RESET_SUSTAIN_LEVEL;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        oav_pkg::REG_WAVE_SELECT:    wave_select    <= cfg_data[oav_pkg::WAVE_W-1:0];
        oav_pkg::REG_PHASE_STEP:     phase_step     <= cfg_data[oav_pkg::STEP_W-1:0];
        oav_pkg::REG_OUTPUT_GAIN:    output_gain    <= cfg_data[oav_pkg::GAIN_W-1:0];
        oav_pkg::REG_ATTACK_LENGTH:  attack_length  <= cfg_data[oav_pkg::LEN_W-1:0];
        oav_pkg::REG_DECAY_LENGTH:   decay_length   <= cfg_data[oav_pkg::LEN_W-1:0];
        oav_pkg::REG_HOLD_LENGTH:    hold_length    <= cfg_data[oav_pkg::LEN_W-1:0];
        oav_pkg::REG_RELEASE_LENGTH: release_length <= cfg_data[oav_pkg::LEN_W-1:0];
        oav_pkg::REG_SUSTAIN_LEVEL:  sustain_level  <= cfg_data[oav_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // stage boundaries, one add per register
  always_ff @(posedge clk) begin
    e2 <= {1'b0, attack_length} + {1'b0, decay_length};
    e3 <= {1'b0, e2} + {2'b00, hold_length};
    e4 <= e3 + {2'b00, release_length};
  end

  assign run       = active && (idx < e4);
  assign phase_sum = SUM_W'(phase) + SUM_W'(phase_step);
  assign lfsr_step = {1'b0, lfsr[oav_pkg::LFSR_W-1:1]} ^ (lfsr[0] ? oav_pkg::LFSR_TAPS : '0);

  always_comb begin
    if (idx < {2'b00, attack_length}) begin
      stage_sel = oav_pkg::STAGE_ATTACK;
      jpos_sel  = idx[oav_pkg::LEN_W-1:0];
    end else if (idx < {1'b0, e2}) begin
      stage_sel = oav_pkg::STAGE_DECAY;
      jpos_sel  = oav_pkg::LEN_W'(idx - {2'b00, attack_length});
    end else if (idx < e3) begin
      stage_sel = oav_pkg::STAGE_SUSTAIN;
      jpos_sel  = '0;
    end else begin
      stage_sel = oav_pkg::STAGE_RELEASE;
      jpos_sel  = oav_pkg::LEN_W'(idx - e3);
    end
  end

  always_comb begin
    case (wave_select)
      oav_pkg::WAVE_SQUARE:   w17 = p16[15] ? 17'h18000 : 17'h08000;
      oav_pkg::WAVE_SAW:      w17 = {~p16[15], ~p16[15], p16[14:0]};
      oav_pkg::WAVE_TRIANGLE: w17 = p16[15] ? (17'h08000 - {1'b0, p16[14:0], 1'b0})
                                            : ({1'b0, p16[14:0], 1'b0} - 17'h08000);
      oav_pkg::WAVE_NOISE:    w17 = {~lfsr[15], ~lfsr[15], lfsr[14:0]};
      default:                w17 = '0;
    endcase
    if (wave_select == oav_pkg::WAVE_SINE) begin
      wave_neg = rom_neg;
      wave_mag = {1'b0, rom_mag};
    end else begin
      wave_neg = w17[16];
      wave_mag = w17[16] ? 16'(-w17) : w17[15:0];
    end
  end

  always_comb begin
    if (stage == oav_pkg::STAGE_SUSTAIN) begin
      env_val = {1'b0, sustain_level};
    end else if (stage == oav_pkg::STAGE_DECAY) begin
      env_val = 17'h10000 - {1'b0, div_q};
    end else begin
      env_val = {1'b0, div_q};
    end
  end

  assign res_mag    = mul_prod[47] ? 16'h7FFF : mul_prod[47:32];
  assign res_sample = wneg ? 16'(-res_mag) : res_mag;

  // voice state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= '0;
      idx    <= '0;
      lfsr   <= oav_pkg::LFSR_SEED;
      active <= 1'b0;
    end else if (accept && s_tdata[0]) begin
      phase  <= '0;
      idx    <= '0;
      active <= 1'b1;
    end else if (state == oav_pkg::ST_EVAL) begin
      if (!run) begin
        active <= 1'b0;
      end else begin
        phase <= phase_sum[PHASE_BITS-1:0];
        idx   <= idx + oav_pkg::INDEX_W'(1);
        if (wave_select == oav_pkg::WAVE_NOISE) begin
          lfsr <= lfsr_step;
        end
      end
    end
  end

  // per-item work registers
  always_ff @(posedge clk) begin
    if (state == oav_pkg::ST_EVAL) begin
      silent <= !run;
      stage  <= stage_sel;
      jpos   <= jpos_sel;
      p16    <= phase[PHASE_BITS-1 -: 16];
    end
    if (state == oav_pkg::ST_SETUP) begin
      wmag <= wave_mag;
      wneg <= wave_neg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= oav_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      oav_pkg::ST_IDLE:  if (accept) state_next = oav_pkg::ST_SUM1;
      oav_pkg::ST_SUM1:  state_next = oav_pkg::ST_SUM2;
      oav_pkg::ST_SUM2:  state_next = oav_pkg::ST_EVAL;
      oav_pkg::ST_EVAL:  state_next = run ? oav_pkg::ST_SETUP : oav_pkg::ST_DONE;
      oav_pkg::ST_SETUP: begin
        if (stage == oav_pkg::STAGE_ATTACK) begin
          state_next = oav_pkg::ST_DIV;
        end else if (stage == oav_pkg::STAGE_SUSTAIN) begin
          state_next = oav_pkg::ST_WGO;
        end else begin
          state_next = oav_pkg::ST_PMUL;
        end
      end
      oav_pkg::ST_PMUL:  if (mul_done) state_next = oav_pkg::ST_DIVGO;
      oav_pkg::ST_DIVGO: state_next = oav_pkg::ST_DIV;
      oav_pkg::ST_DIV:   if (div_done) state_next = oav_pkg::ST_WGO;
      oav_pkg::ST_WGO:   state_next = oav_pkg::ST_WMUL;
      oav_pkg::ST_WMUL:  if (mul_done) state_next = oav_pkg::ST_GGO;
      oav_pkg::ST_GGO:   state_next = oav_pkg::ST_GMUL;
      oav_pkg::ST_GMUL:  if (mul_done) state_next = oav_pkg::ST_DONE;
      oav_pkg::ST_DONE:  if (out_free) state_next = oav_pkg::ST_IDLE;
      default:           state_next = oav_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_hi    = '0;
    div_lo    = '0;
    div_d     = '0;
    unique case (state)
      oav_pkg::ST_IDLE: s_tready = 1'b1;
      oav_pkg::ST_SETUP: begin
        if (stage == oav_pkg::STAGE_ATTACK) begin
          div_start = 1'b1;
          div_hi    = jpos;
          div_d     = attack_length;
        end else if (stage == oav_pkg::STAGE_DECAY) begin
          mul_start = 1'b1;
          mul_a     = oav_pkg::MUL_A_W'(jpos);
          mul_b     = 17'h10000 - {1'b0, sustain_level};
        end else if (stage == oav_pkg::STAGE_RELEASE) begin
          mul_start = 1'b1;
          mul_a     = oav_pkg::MUL_A_W'(release_length - jpos);
          mul_b     = {1'b0, sustain_level};
        end
      end
      oav_pkg::ST_DIVGO: begin
        div_start = 1'b1;
        div_hi    = mul_prod[35:16];
        div_lo    = mul_prod[15:0];
        div_d     = (stage == oav_pkg::STAGE_DECAY) ? decay_length : release_length;
      end
      oav_pkg::ST_WGO: begin
        mul_start = 1'b1;
        mul_a     = oav_pkg::MUL_A_W'(env_val);
        mul_b     = {1'b0, wmag};
      end
      oav_pkg::ST_GGO: begin
        mul_start = 1'b1;
        mul_a     = mul_prod[oav_pkg::MUL_A_W-1:0];
        mul_b     = {1'b0, output_gain};
      end
      default: ;
    endcase
  end

  // output register: hold the item until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == oav_pkg::ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == oav_pkg::ST_DONE && out_free) begin
      out_sample <= silent ? '0 : res_sample;
      out_stage  <= silent ? oav_pkg::STAGE_IDLE : stage;
    end
  end

  oav_sine_rom #(
    .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
  ) u_sine_rom (
    .clk  (clk),
    .addr (phase[PHASE_BITS-1 -: SINE_IDX_W]),
    .mag  (rom_mag),
    .neg  (rom_neg)
  );

  oav_serial_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .product (mul_prod),
    .done    (mul_done)
  );

  oav_serial_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num_hi   (div_hi),
    .num_lo   (div_lo),
    .divisor  (div_d),
    .quotient (div_q),
    .done     (div_done)
  );

endmodule
`default_nettype wire
